[rtl/core/sorted_key_set_assert.svh]
// Assertion macros used by the sks_check checker of sorted_key_set.
`ifndef SORTED_KEY_SET_ASSERT_SVH
`define SORTED_KEY_SET_ASSERT_SVH

// Checked while out of reset.
`define SKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SKS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sks_pkg.sv]
package sks_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic update;
    logic report;
  } sks_cmd_t;

  typedef struct packed {
    status_t                    status;
    logic                       found;
    logic [COUNT_W-1:0]         count;
    logic signed [KEY_W-1:0]    min_key;
    logic signed [KEY_W-1:0]    max_key;
    logic                       has_pred;
    logic signed [KEY_W-1:0]    pred_key;
    logic                       has_succ;
    logic signed [KEY_W-1:0]    succ_key;
  } sks_res_t;

  function automatic logic [COUNT_W-1:0] to_out_count(input logic [CNT_W-1:0] c);
    return COUNT_W'(c);
  endfunction

endpackage

[rtl/core/sks_if.sv]
interface sks_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface sks_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic [4:0]         count;
  logic signed [31:0] min_key;
  logic signed [31:0] max_key;
  logic               has_pred;
  logic signed [31:0] pred_key;
  logic               has_succ;
  logic signed [31:0] succ_key;

  modport source (output valid, output status, output found, output count,
                  output min_key, output max_key, output has_pred, output pred_key,
                  output has_succ, output succ_key, input ready);
  modport sink   (input valid, input status, input found, input count,
                  input min_key, input max_key, input has_pred, input pred_key,
                  input has_succ, input succ_key, output ready);
endinterface

[rtl/core/sks_datapath.sv]
module sks_datapath
  import sks_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  sks_cmd_t                cmd,
  input  logic [1:0]              in_opcode,
  input  logic signed [KEY_W-1:0] in_key,
  output sks_res_t                res
);

  opcode_t                 op_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] keys_r [CAPACITY];
  logic signed [KEY_W-1:0] keys_nxt [CAPACITY];
  logic signed [KEY_W-1:0] prev_key [CAPACITY];
  logic signed [KEY_W-1:0] next_key [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 status_r, status_nxt;
  sks_res_t                res_r, res_nxt;

  logic [CAPACITY-1:0] vld, lt, eq, gt;
  logic [CAPACITY-1:0] ins_here, pred_sel, succ_sel, max_sel;
  logic                full;

  // cell compares against the held key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vld[i] = CNT_W'(i) < count_r;
      lt[i]  = vld[i] && (keys_r[i] < key_r);
      eq[i]  = vld[i] && (keys_r[i] == key_r);
      gt[i]  = vld[i] && (keys_r[i] > key_r);
    end
    prev_key[0] = key_r;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_key[i] = keys_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      next_key[i] = keys_r[i+1];
    end
    next_key[CAPACITY-1] = keys_r[CAPACITY-1];
  end

  assign full     = count_r == CNT_W'(CAPACITY);
  assign ins_here = ~lt & ((lt << 1) | CAPACITY'(1));
  assign pred_sel = lt & ~(lt >> 1);
  assign succ_sel = gt & ~(gt << 1);
  assign max_sel  = vld & ~(vld >> 1);

  // shift update
  always_comb begin
    keys_nxt   = keys_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (ins_here[i]) keys_nxt[i] = key_r;
            else if (!lt[i]) keys_nxt[i] = prev_key[i];
          end
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      OP_DELETE: begin
        if (|eq) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!lt[i]) keys_nxt[i] = next_key[i];
          end
          count_nxt = CNT_W'(count_r - 1'b1);
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      default: ;
    endcase
  end

  // report on the updated chain
  always_comb begin
    res_nxt          = '0;
    res_nxt.status   = status_r;
    res_nxt.found    = |eq;
    res_nxt.count    = to_out_count(count_r);
    res_nxt.has_pred = |lt;
    res_nxt.has_succ = |gt;
    if (count_r != '0) res_nxt.min_key = keys_r[0];
    for (int i = 0; i < CAPACITY; i++) begin
      res_nxt.max_key  = res_nxt.max_key  | ({KEY_W{max_sel[i]}}  & keys_r[i]);
      res_nxt.pred_key = res_nxt.pred_key | ({KEY_W{pred_sel[i]}} & keys_r[i]);
      res_nxt.succ_key = res_nxt.succ_key | ({KEY_W{succ_sel[i]}} & keys_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= in_key;
    end
    if (cmd.update) begin
      keys_r   <= keys_nxt;
      status_r <= status_nxt;
    end
    if (cmd.report) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[rtl/core/sks_ctrl.sv]
module sks_ctrl
  import sks_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sks_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_REPORT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free     = !out_valid_r || out_ready;
  assign in_ready      = state_r == S_IDLE;
  assign out_valid     = out_valid_r;
  assign cmd.load      = in_valid && in_ready;
  assign cmd.update    = state_r == S_UPDATE;
  assign cmd.report    = (state_r == S_REPORT) && slot_free;
  assign out_valid_nxt = cmd.report || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          state_r <= S_REPORT;
        end
        S_REPORT: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/sorted_key_set.sv]
// channel  dir  fields
// in_ch    in   opcode[1:0], key[31:0] signed
// out_ch   out  status, found, count, min/max_key, has/pred_key, has/succ_key
//
// Each word takes three steps: capture, shift update of the 16-cell key chain,
// then a full compare of the updated chain into the result register.
// rst_n clears the entry count and the handshake state; cell contents are
// kept. The next word is taken while a result still waits; a stalled out_ch
// holds the following result in its report step.
module sorted_key_set
  import sks_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  sks_in_if.sink   in_ch,
  sks_out_if.source out_ch
);

  sks_cmd_t cmd;
  sks_res_t res;

  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sks_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_opcode (in_ch.opcode),
    .in_key    (in_ch.key),
    .res       (res)
  );

  assign out_ch.status   = res.status;
  assign out_ch.found    = res.found;
  assign out_ch.count    = res.count;
  assign out_ch.min_key  = res.min_key;
  assign out_ch.max_key  = res.max_key;
  assign out_ch.has_pred = res.has_pred;
  assign out_ch.pred_key = res.pred_key;
  assign out_ch.has_succ = res.has_succ;
  assign out_ch.succ_key = res.succ_key;

endmodule

[rtl/core/sks_check.sv]
`include "sorted_key_set_assert.svh"

module sks_check
  import sks_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [4:0]         out_count,
  input logic signed [31:0] out_min_key,
  input logic               out_has_pred,
  input logic signed [31:0] out_pred_key
);

  `SKS_ASSERT_ANY(a_rst_idle, !rst_n |=> !out_valid, "out valid after reset")
  `SKS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_count), "word dropped")
  `SKS_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `SKS_ASSERT(a_full_cnt, out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(CAPACITY), "full status below capacity")
  `SKS_ASSERT(a_pred_min, out_valid && out_has_pred |-> out_pred_key >= out_min_key, "pred below min")

endmodule

bind sorted_key_set sks_check u_sks_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count),
  .out_min_key  (out_ch.min_key),
  .out_has_pred (out_ch.has_pred),
  .out_pred_key (out_ch.pred_key)
);

[tb/sorted_key_set_checker.sv]
`timescale 1ns / 100ps

module sorted_key_set_checker
  import sks_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sks_in_if    in_mon,
  sks_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  logic signed [KEY_W-1:0] held_keys [CAPACITY];
  int                      held_count;
  sks_res_t                expected_q [$];
  sks_res_t                want;

  // Apply one word to the local copy of the set and build its result.
  function automatic sks_res_t apply_set_op(input logic [1:0] op,
                                            input logic signed [KEY_W-1:0] k);
    sks_res_t                r;
    int                      pos;
    int                      i;
    logic signed [KEY_W-1:0] v;
    r = '0;
    r.status = ST_OK;
    pos = 0;
    while (pos < held_count && held_keys[pos] < k) pos++;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
        held_keys[pos] = k;
        held_count++;
      end
    end else if (op == OP_DELETE) begin
      if (pos < held_count && held_keys[pos] == k) begin
        for (i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end else begin
        r.status = ST_ABSENT;
      end
    end
    for (i = 0; i < held_count; i++) begin
      v = held_keys[i];
      if (v == k) begin
        r.found = 1'b1;
      end else if (v < k) begin
        r.has_pred = 1'b1;
        r.pred_key = v;
      end else if (!r.has_succ) begin
        r.has_succ = 1'b1;
        r.succ_key = v;
      end
    end
    if (held_count > 0) begin
      r.min_key = held_keys[0];
      r.max_key = held_keys[held_count-1];
    end
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                             input logic [KEY_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    held_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(apply_set_op(in_mon.opcode, in_mon.key));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_mon.status));
          check_field("found", 32'(want.found), 32'(out_mon.found));
          check_field("count", 32'(want.count), 32'(out_mon.count));
          check_field("min_key", want.min_key, out_mon.min_key);
          check_field("max_key", want.max_key, out_mon.max_key);
          check_field("has_pred", 32'(want.has_pred), 32'(out_mon.has_pred));
          check_field("pred_key", want.pred_key, out_mon.pred_key);
          check_field("has_succ", 32'(want.has_succ), 32'(out_mon.has_succ));
          check_field("succ_key", want.succ_key, out_mon.succ_key);
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

[tb/sorted_key_set_tb.sv]
`timescale 1ns / 100ps

module sorted_key_set_tb;
  import sks_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_WORDS = 1800;
  localparam int PHASE_WORDS  = 150;
  localparam int BURST_WORDS  = 30;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  sks_in_if  in_ch ();
  sks_out_if out_ch ();

  sorted_key_set uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_key_set_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    out_ch.ready <= !($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] fresh_key();
    case ($urandom_range(3))
      0: return int'($urandom_range(20)) - 10;
      1: begin
        case ($urandom_range(3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return KEY_MIN + 1;
          default: return KEY_MAX - 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] key_pool [8];
    logic [1:0]         op;
    logic signed [31:0] k;
    int                 sent;
    int                 ins_pct;
    int                 roll;
    int                 i;
    int                 n;

    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_QUERY;
    in_ch.key      <= '0;
    rst_n          <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty set, extremes, duplicates, absent delete, unused opcode
    send_word(OP_QUERY, 32'sd0);
    send_word(OP_DELETE, 32'sd0);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_QUERY, 32'sd0);
    send_word(OP_QUERY, 32'sd1);
    send_word(OP_QUERY, -32'sd1);
    send_word(OP_UNUSED, 32'sd5);
    send_word(OP_QUERY, KEY_MIN);
    send_word(OP_QUERY, KEY_MAX);
    send_word(OP_DELETE, 32'sd7);
    send_word(OP_DELETE, 32'sd0);
    send_word(OP_QUERY, 32'sd0);
    send_word(OP_DELETE, KEY_MIN);
    send_word(OP_DELETE, KEY_MAX);
    send_word(OP_DELETE, 32'sd0);
    send_word(OP_QUERY, KEY_MAX);
    send_word(OP_UNUSED, KEY_MIN);

    sent = 0;
    ins_pct = 50;
    while (sent < RANDOM_WORDS) begin
      case ((sent / PHASE_WORDS) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (sent % BURST_WORDS == 0) begin
        for (i = 0; i < 8; i++) key_pool[i] = fresh_key();
        case ($urandom_range(2))
          0: ins_pct = 85;
          1: ins_pct = 50;
          default: ins_pct = 20;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 4) op = OP_UNUSED;
      else if (roll < 16) op = OP_QUERY;
      else if ((roll - 16) < ins_pct * 84 / 100) op = OP_INSERT;
      else op = OP_DELETE;
      if ($urandom_range(99) < 85) k = key_pool[$urandom_range(7)];
      else k = $urandom;
      send_word(op, k);
      sent++;
    end
    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;

    for (n = 0; n < 5000 && pending_count != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/sks_pkg.sv
rtl/core/sks_if.sv
rtl/core/sks_datapath.sv
rtl/core/sks_ctrl.sv
rtl/core/sorted_key_set.sv
rtl/core/sks_check.sv
tb/sorted_key_set_checker.sv
tb/sorted_key_set_tb.sv
